/* hw/rtl/dvit_pkg.sv */
// ----------------------------------------------------------------------------
// dvit_pkg
// Shared constants and the response type for the detection vote interval
// tracker: csr indexes, field widths, request command codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dvit_pkg;

   localparam int LOGIT_W   = 16;
   localparam int LEN_W     = 4;
   localparam int LIMIT_W   = 16;
   localparam int OUT_IDX_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DAT_W = 32;
   localparam int RSP_DAT_W = 168;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_LOGIT_THRESHOLD   = 3'd0;
   localparam csr_index_type CSR_SMOOTH_LEN        = 3'd1;
   localparam csr_index_type CSR_MAX_RUN_WINDOWS   = 3'd2;
   localparam csr_index_type CSR_MAX_GAP_WINDOWS   = 3'd3;
   localparam csr_index_type CSR_MERGE_GAP_WINDOWS = 3'd4;

   localparam logic CMD_WINDOW = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic signed [LOGIT_W-1:0] RST_LOGIT_THRESHOLD   = 16'sd0;
   localparam logic        [LEN_W-1:0]   RST_SMOOTH_LEN        = 4'd5;
   localparam logic        [LIMIT_W-1:0] RST_MAX_RUN_WINDOWS   = 16'd50;
   localparam logic        [LIMIT_W-1:0] RST_MAX_GAP_WINDOWS   = 16'd150;
   localparam logic        [LIMIT_W-1:0] RST_MERGE_GAP_WINDOWS = 16'd26;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] rally_final;
      logic [OUT_IDX_W-1:0] rally_first;
      logic                 rally_done;
      logic [OUT_IDX_W-1:0] hit_final;
      logic [OUT_IDX_W-1:0] hit_first;
      logic                 hit_done;
      logic                 rally_flag;
      logic                 kept_vote;
      logic                 smooth_vote;
      logic                 raw_vote;
      logic [OUT_IDX_W-1:0] window_index;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/detection_vote_interval_tracker.sv */
// ----------------------------------------------------------------------------
// detection_vote_interval_tracker
// Thresholds classifier logit pairs, majority-smooths the votes, limits run
// length, tracks rally state and merges kept windows into hit intervals.
//
// Usage: each request carries one window (tuser = 0, tdata = logits) or an
// end-of-stream flush (tuser = 1). Every request yields exactly one response
// with the window index, the vote chain, the rally flag and any hit or rally
// interval that closes with it. A flush reports open intervals and clears all
// tracking state; the csr registers keep their values.
// A request passes through the request register and then the response
// register. One request is taken per cycle while rsp_tready is high; the
// single state update per cycle between the two registers sets that rate.
// When rsp_tready is low the response register holds, the request
// register fills, and req_tready drops once both are occupied.
// Reset clears both stages, all tracking state and loads the register
// defaults. csr writes are taken in any cycle but are only meant while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_vote_interval_tracker #(
   parameter int MAX_SMOOTH = 15,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [dvit_pkg::REQ_DAT_W-1:0]       req_tdata,  // logit_neg, logit_pos
   input  wire logic                                 req_tuser,  // cmd
   // response channel
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // window_index, raw_vote, smooth_vote, kept_vote, rally_flag, hit_done,
   // hit_first, hit_final, rally_done, rally_first, rally_final, zero pad
   output      logic [dvit_pkg::RSP_DAT_W-1:0]       rsp_tdata,
   // csr write port
   input  wire logic                                 csr_wen,
   input  wire dvit_pkg::csr_index_type              csr_index,
   input  wire logic [dvit_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   localparam int FILL_W = $clog2(MAX_SMOOTH + 1);
   localparam int SUM_W  = FILL_W + 1;
   localparam int EXT_W  = INDEX_BITS + dvit_pkg::OUT_IDX_W;
   localparam int RSP_W  = $bits(dvit_pkg::rsp_type);

   // csr registers
   logic signed [dvit_pkg::LOGIT_W-1:0] thresh_ff;
   logic [dvit_pkg::LEN_W-1:0]          smooth_len_ff;
   logic [dvit_pkg::LIMIT_W-1:0]        max_run_ff;
   logic [dvit_pkg::LIMIT_W-1:0]        max_gap_ff;
   logic [dvit_pkg::LIMIT_W-1:0]        merge_gap_ff;

   // request stage
   logic                                in_valid_ff;
   logic                                in_cmd_ff;
   logic signed [dvit_pkg::LOGIT_W-1:0] in_neg_ff;
   logic signed [dvit_pkg::LOGIT_W-1:0] in_pos_ff;

   // response stage
   logic                                out_valid_ff;
   dvit_pkg::rsp_type                   out_data_ff;
   dvit_pkg::rsp_type                   out_data_in;

   // tracking state
   logic [MAX_SMOOTH-1:0] hist_ff,         hist_in;
   logic [FILL_W-1:0]     fill_ff,         fill_in;
   logic [INDEX_BITS-1:0] counter_ff,      counter_in;
   logic                  run_active_ff,   run_active_in;
   logic [INDEX_BITS-1:0] run_begin_ff,    run_begin_in;
   logic [INDEX_BITS-1:0] last_hit_ff,     last_hit_in;
   logic                  rally_active_ff, rally_active_in;
   logic [INDEX_BITS-1:0] rally_begin_ff,  rally_begin_in;
   logic                  hit_open_ff,     hit_open_in;
   logic [INDEX_BITS-1:0] hit_begin_ff,    hit_begin_in;
   logic [INDEX_BITS-1:0] hit_latest_ff,   hit_latest_in;

   logic                  advance;
   logic signed [dvit_pkg::LOGIT_W:0] diff;
   logic                  raw;
   logic [FILL_W-1:0]     len;
   logic [MAX_SMOOTH:0]   hist_shift;
   logic [SUM_W-1:0]      vote_sum;
   logic                  smooth;
   logic                  kept;
   logic                  rally_close;
   logic                  hit_close;
   logic [INDEX_BITS-1:0] rally_final_idx;

   function automatic logic [dvit_pkg::OUT_IDX_W-1:0] to_out(
      input logic [INDEX_BITS-1:0] v
   );
      logic [EXT_W-1:0] ext;
      ext = {{dvit_pkg::OUT_IDX_W{1'b0}}, v};
      return ext[dvit_pkg::OUT_IDX_W-1:0];
   endfunction

   function automatic logic [INDEX_BITS-1:0] limit_ext(
      input logic [dvit_pkg::LIMIT_W-1:0] v
   );
      return {{(INDEX_BITS - dvit_pkg::LIMIT_W){1'b0}}, v};
   endfunction

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(dvit_pkg::RSP_DAT_W - RSP_W){1'b0}}, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= dvit_pkg::RST_LOGIT_THRESHOLD;
         smooth_len_ff <= dvit_pkg::RST_SMOOTH_LEN;
         max_run_ff    <= dvit_pkg::RST_MAX_RUN_WINDOWS;
         max_gap_ff    <= dvit_pkg::RST_MAX_GAP_WINDOWS;
         merge_gap_ff  <= dvit_pkg::RST_MERGE_GAP_WINDOWS;
      end else if (csr_wen) begin
         case (csr_index)
            dvit_pkg::CSR_LOGIT_THRESHOLD:   thresh_ff     <= csr_wdata;
            dvit_pkg::CSR_SMOOTH_LEN:        smooth_len_ff <= csr_wdata[dvit_pkg::LEN_W-1:0];
            dvit_pkg::CSR_MAX_RUN_WINDOWS:   max_run_ff    <= csr_wdata;
            dvit_pkg::CSR_MAX_GAP_WINDOWS:   max_gap_ff    <= csr_wdata;
            dvit_pkg::CSR_MERGE_GAP_WINDOWS: merge_gap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_neg_ff <= req_tdata[dvit_pkg::LOGIT_W-1:0];
         in_pos_ff <= req_tdata[2*dvit_pkg::LOGIT_W-1:dvit_pkg::LOGIT_W];
      end
   end

   // vote chain
   always_comb begin
      diff = {in_pos_ff[dvit_pkg::LOGIT_W-1], in_pos_ff}
           - {in_neg_ff[dvit_pkg::LOGIT_W-1], in_neg_ff};
      raw  = (diff >= $signed({thresh_ff[dvit_pkg::LOGIT_W-1], thresh_ff}));

      if (smooth_len_ff == '0) begin
         len = FILL_W'(1);
      end else if (32'(smooth_len_ff) > MAX_SMOOTH) begin
         len = FILL_W'(MAX_SMOOTH);
      end else begin
         len = FILL_W'(smooth_len_ff);
      end

      hist_shift = {hist_ff, raw};
      vote_sum   = '0;
      for (int i = 0; i < MAX_SMOOTH; i++) begin
         if (32'(i) < 32'(fill_in) && hist_shift[i]) begin
            vote_sum = vote_sum + SUM_W'(1);
         end
      end
      smooth = ({vote_sum, 1'b0} > {2'b00, fill_in});

      kept = smooth && !(run_active_ff
                         && ((counter_ff - run_begin_ff) > limit_ext(max_run_ff)));

      rally_close = !kept && rally_active_ff
                    && ((counter_ff - last_hit_ff) > limit_ext(max_gap_ff));
      hit_close   = hit_open_ff
                    && ((counter_ff - hit_latest_ff) > limit_ext(merge_gap_ff));
   end

   always_comb begin
      fill_in = (fill_ff < len) ? fill_ff + FILL_W'(1) : len;
   end

   // state and response update
   always_comb begin
      hist_in         = hist_ff;
      counter_in      = counter_ff;
      run_active_in   = run_active_ff;
      run_begin_in    = run_begin_ff;
      last_hit_in     = last_hit_ff;
      rally_active_in = rally_active_ff;
      rally_begin_in  = rally_begin_ff;
      hit_open_in     = hit_open_ff;
      hit_begin_in    = hit_begin_ff;
      hit_latest_in   = hit_latest_ff;
      rally_final_idx = counter_ff - INDEX_BITS'(1);
      out_data_in     = '0;
      out_data_in.window_index = to_out(counter_ff);

      if (in_cmd_ff == dvit_pkg::CMD_FLUSH) begin
         if (hit_open_ff) begin
            out_data_in.hit_done  = 1'b1;
            out_data_in.hit_first = to_out(hit_begin_ff);
            out_data_in.hit_final = to_out(hit_latest_ff);
         end
         if (rally_active_ff) begin
            out_data_in.rally_done  = 1'b1;
            out_data_in.rally_first = to_out(rally_begin_ff);
            out_data_in.rally_final = (counter_ff == '0) ? '0 : to_out(rally_final_idx);
         end
         hist_in         = '0;
         counter_in      = '0;
         run_active_in   = 1'b0;
         run_begin_in    = '0;
         last_hit_in     = '0;
         rally_active_in = 1'b0;
         rally_begin_in  = '0;
         hit_open_in     = 1'b0;
         hit_begin_in    = '0;
         hit_latest_in   = '0;
      end else begin
         hist_in = hist_shift[MAX_SMOOTH-1:0];

         if (smooth) begin
            if (!run_active_ff) begin
               run_active_in = 1'b1;
               run_begin_in  = counter_ff;
            end
         end else begin
            run_active_in = 1'b0;
         end

         if (kept) begin
            last_hit_in = counter_ff;
            if (!rally_active_ff) begin
               rally_active_in = 1'b1;
               rally_begin_in  = counter_ff;
            end
         end else if (rally_close) begin
            rally_active_in         = 1'b0;
            out_data_in.rally_done  = 1'b1;
            out_data_in.rally_first = to_out(rally_begin_ff);
            out_data_in.rally_final = to_out(rally_final_idx);
         end

         if (hit_close) begin
            out_data_in.hit_done  = 1'b1;
            out_data_in.hit_first = to_out(hit_begin_ff);
            out_data_in.hit_final = to_out(hit_latest_ff);
         end
         if (kept) begin
            hit_open_in   = 1'b1;
            hit_latest_in = counter_ff;
            if (!hit_open_ff || hit_close) begin
               hit_begin_in = counter_ff;
            end
         end else if (hit_close) begin
            hit_open_in = 1'b0;
         end

         out_data_in.raw_vote    = raw;
         out_data_in.smooth_vote = smooth;
         out_data_in.kept_vote   = kept;
         out_data_in.rally_flag  = rally_active_in;
         if (!(&counter_ff)) begin
            counter_in = counter_ff + INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff         <= '0;
         fill_ff         <= '0;
         counter_ff      <= '0;
         run_active_ff   <= 1'b0;
         run_begin_ff    <= '0;
         last_hit_ff     <= '0;
         rally_active_ff <= 1'b0;
         rally_begin_ff  <= '0;
         hit_open_ff     <= 1'b0;
         hit_begin_ff    <= '0;
         hit_latest_ff   <= '0;
      end else if (advance) begin
         hist_ff         <= hist_in;
         fill_ff         <= (in_cmd_ff == dvit_pkg::CMD_FLUSH) ? '0 : fill_in;
         counter_ff      <= counter_in;
         run_active_ff   <= run_active_in;
         run_begin_ff    <= run_begin_in;
         last_hit_ff     <= last_hit_in;
         rally_active_ff <= rally_active_in;
         rally_begin_ff  <= rally_begin_in;
         hit_open_ff     <= hit_open_in;
         hit_begin_ff    <= hit_begin_in;
         hit_latest_ff   <= hit_latest_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire
